FILE: rtl/gdd_pkg.sv
`timescale 1ns / 1ps

package gdd_pkg;

  // Both dates of one item
  typedef struct packed {
    logic [4:0]  day_a;
    logic [3:0]  month_a;
    logic [13:0] year_a;
    logic [4:0]  day_b;
    logic [3:0]  month_b;
    logic [13:0] year_b;
  } dates_t;

  typedef struct packed {
    logic [1:0]  order;
    logic [21:0] days_apart;
    logic        valid_a;
    logic        valid_b;
  } result_t;

  // One date as seen by an ordinal lane
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } date_t;

  localparam int unsigned ORD_W = 23;

  // Lane output: ordinal day number and day-fits-month flag
  typedef struct packed {
    logic [ORD_W-1:0] ordinal;
    logic             fits;
  } lane_t;

  localparam logic [1:0] ORD_EQUAL   = 2'd0;
  localparam logic [1:0] ORD_EARLIER = 2'd1;
  localparam logic [1:0] ORD_LATER   = 2'd2;

  // floor(x/25) = (x * RECIP_25) >> RECIP_SHIFT, exact for x < 43690
  localparam logic [12:0] RECIP_25    = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 17;

  localparam logic [8:0]  DAYS_YEAR = 9'd365;
  localparam logic [21:0] DAYS_MAX  = 22'h3FFFFF;

  // Days before month m in a common year; month 0 counts as January
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      4'd13:   r = 9'd365;
      4'd14:   r = 9'd396;
      default: r = 9'd427;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/gdd_lane.sv
`timescale 1ns / 1ps

// Ordinal day number of one date, three register stages:
//   s1: constant-reciprocal products for /100, /400, /4/25 and 365*y
//   s2: quotients, leap test, fits test, base and small correction
//   s3: ordinal = base + correction
module gdd_lane (
  input  logic           clk,
  input  gdd_pkg::date_t date,
  output gdd_pkg::lane_t lane
);

  // stage 1
  logic [4:0]  day1;
  logic [3:0]  month1;
  logic [13:0] year1;
  logic [25:0] p100;
  logic [23:0] p400;
  logic [24:0] p4;
  logic [22:0] p365;

  logic [14:0] y99;
  logic [14:0] y399;
  logic [12:0] x100;
  logic [10:0] x400;

  assign y99  = {1'b0, date.year} + 15'd99;
  assign y399 = {1'b0, date.year} + 15'd399;
  assign x100 = y99[14:2];
  assign x400 = y399[14:4];

  always_ff @(posedge clk) begin
    day1   <= date.day;
    month1 <= date.month;
    year1  <= date.year;
    p100   <= {13'b0, x100} * {13'b0, gdd_pkg::RECIP_25};
    p400   <= {13'b0, x400} * {11'b0, gdd_pkg::RECIP_25};
    p4     <= {13'b0, date.year[13:2]} * {12'b0, gdd_pkg::RECIP_25};
    p365   <= {9'b0, date.year} * {14'b0, gdd_pkg::DAYS_YEAR};
  end

  // stage 2
  logic [8:0]  q100;
  logic [6:0]  q400;
  logic [7:0]  q4;
  logic [12:0] q4x25;
  logic        div100;
  logic        div400;
  logic        leap;
  logic [14:0] y3;
  logic [9:0]  inyr;
  logic        fits_c;

  logic [22:0] base_next;
  logic [10:0] corr_next;

  assign q100  = p100[25:gdd_pkg::RECIP_SHIFT];
  assign q400  = p400[23:gdd_pkg::RECIP_SHIFT];
  assign q4    = p4[24:gdd_pkg::RECIP_SHIFT];
  assign q4x25 = {5'b0, q4} * 13'd25;

  // y%100==0: y%4==0 and (y/4)%25==0; y%400==0: also (y/100)%4==0
  assign div100 = (year1[1:0] == 2'b00) && ({1'b0, year1[13:2]} == q4x25);
  assign div400 = div100 && (q4[1:0] == 2'b00);
  assign leap   = ((year1[1:0] == 2'b00) && !div100) || div400;

  assign y3   = {1'b0, year1} + 15'd3;
  assign inyr = {1'b0, gdd_pkg::cum_days(month1)}
              + {9'b0, (month1 >= 4'd3) && leap}
              + {5'b0, day1};

  assign fits_c = (month1 >= 4'd1) && (month1 <= 4'd12) && (day1 != 5'd0)
               && (day1 <= gdd_pkg::month_len(month1, leap));

  assign base_next = p365 + {10'b0, y3[14:2]};
  assign corr_next = {1'b0, inyr} + {4'b0, q400} - {2'b0, q100};

  logic [22:0] base2;
  logic [10:0] corr2;
  logic        fits2;

  always_ff @(posedge clk) begin
    base2 <= base_next;
    corr2 <= corr_next;
    fits2 <= fits_c;
  end

  // stage 3; correction is two's complement, the total is never negative
  always_ff @(posedge clk) begin
    lane.ordinal <= base2 + {{12{corr2[10]}}, corr2};
    lane.fits    <= fits2;
  end

endmodule

FILE: rtl/gdd_diff.sv
`timescale 1ns / 1ps

// Output stage: absolute distance with saturation, result register, strobe
module gdd_diff (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  logic [1:0]        order,
  input  gdd_pkg::lane_t    lane_a,
  input  gdd_pkg::lane_t    lane_b,
  output logic              done,
  output gdd_pkg::result_t  result
);

  logic [23:0] ab;
  logic [23:0] ba;
  logic [22:0] mag;

  assign ab  = {1'b0, lane_a.ordinal} - {1'b0, lane_b.ordinal};
  assign ba  = {1'b0, lane_b.ordinal} - {1'b0, lane_a.ordinal};
  assign mag = ab[23] ? ba[22:0] : ab[22:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  always_ff @(posedge clk) begin
    result.order      <= order;
    result.days_apart <= mag[22] ? gdd_pkg::DAYS_MAX : mag[21:0];
    result.valid_a    <= lane_a.fits;
    result.valid_b    <= lane_b.fits;
  end

endmodule

FILE: rtl/gregorian_date_difference.sv
`timescale 1ns / 1ps

// Gregorian date difference: days between two dates, their order, validity.
//
// Input: an item (two dates in dates) is taken at each rising edge where
// start is high and busy is low. busy is a registered copy of rst, so it
// follows reset and stays high in the cycle after reset is released;
// otherwise the block takes an item every cycle.
// Output: done pulses for one cycle with result holding order, days_apart
// (saturated at 2^22-1), valid_a and valid_b. Results leave in the order
// items entered.
// Throughput: one item per cycle while busy is low, set by the fully
// pipelined lanes.
// Stages: s1 constant-reciprocal multiplies, s2 quotients/leap/fits,
// s3 ordinal add, s4 absolute difference and output register.
// Reset clears the valid pipeline; items in flight are dropped.
// The receiver cannot stall: done/result are shown for exactly one cycle.
module gregorian_date_difference (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  gdd_pkg::dates_t   dates,
  output logic              done,
  output gdd_pkg::result_t  result
);

  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Field-by-field order: year, then month, then day
  logic [1:0] order_next;

  always_comb begin
    priority if (dates.year_a != dates.year_b) begin
      order_next = (dates.year_a > dates.year_b) ? gdd_pkg::ORD_LATER
                                                 : gdd_pkg::ORD_EARLIER;
    end else if (dates.month_a != dates.month_b) begin
      order_next = (dates.month_a > dates.month_b) ? gdd_pkg::ORD_LATER
                                                   : gdd_pkg::ORD_EARLIER;
    end else if (dates.day_a != dates.day_b) begin
      order_next = (dates.day_a > dates.day_b) ? gdd_pkg::ORD_LATER
                                               : gdd_pkg::ORD_EARLIER;
    end else begin
      order_next = gdd_pkg::ORD_EQUAL;
    end
  end

  // Valid bits and order travel beside the lanes' three stages
  logic [2:0] vld;
  logic [1:0] order1;
  logic [1:0] order2;
  logic [1:0] order3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 3'b000;
    end else begin
      vld <= {vld[1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    order1 <= order_next;
    order2 <= order1;
    order3 <= order2;
  end

  gdd_pkg::date_t date_a;
  gdd_pkg::date_t date_b;
  gdd_pkg::lane_t lane_a;
  gdd_pkg::lane_t lane_b;

  assign date_a.day   = dates.day_a;
  assign date_a.month = dates.month_a;
  assign date_a.year  = dates.year_a;
  assign date_b.day   = dates.day_b;
  assign date_b.month = dates.month_b;
  assign date_b.year  = dates.year_b;

  gdd_lane u_lane_a (
    .clk  (clk),
    .date (date_a),
    .lane (lane_a)
  );

  gdd_lane u_lane_b (
    .clk  (clk),
    .date (date_b),
    .lane (lane_b)
  );

  gdd_diff u_diff (
    .clk    (clk),
    .rst    (rst),
    .valid  (vld[2]),
    .order  (order3),
    .lane_a (lane_a),
    .lane_b (lane_b),
    .done   (done),
    .result (result)
  );

endmodule

FILE: rtl/gdd_checker.sv
`timescale 1ns / 1ps

module gdd_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input gdd_pkg::dates_t   dates,
  input logic              done,
  input gdd_pkg::result_t  result
);

  // every accepted item comes out on done after the lanes and the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted item did not complete after four cycles");

  // no result without a matching accepted item earlier in the pipeline
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without a matching item");

  // equal dates are zero days apart
  a_equal_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.order == gdd_pkg::ORD_EQUAL) |-> (result.days_apart == 22'd0))
    else $error("equal dates with nonzero distance");

  // equal dates have the same validity
  a_equal_fits: assert property (@(posedge clk) disable iff (rst)
    (done && result.order == gdd_pkg::ORD_EQUAL) |-> (result.valid_a == result.valid_b))
    else $error("equal dates with different validity");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (.*);

FILE: dv/date_diff_checker.sv
`timescale 1ns / 1ps

// Watches both sides of the date difference block, predicts each result
// from the accepted item and checks it against what comes out on done.
module date_diff_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  gdd_pkg::dates_t  dates,
  input  logic             done,
  input  gdd_pkg::result_t result,
  output int unsigned      mismatches,
  output int unsigned      outstanding
);

  gdd_pkg::result_t pending_results[$];

  function automatic int unsigned common_len(input int unsigned m);
    case (m)
      2:           return 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Days since the start of year 0; out-of-range months keep adding 31 each
  function automatic int unsigned day_number(input logic [4:0] d, input logic [3:0] m,
                                             input logic [13:0] y);
    int unsigned yy;
    int unsigned n;
    int unsigned k;
    yy = 32'(y);
    n = 365 * yy + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
    for (k = 1; k < 32'(m); k++)
      n += (k > 12) ? 31 : common_len(k);
    if (m >= 4'd3 && leap_year(yy))
      n += 1;
    return n + 32'(d);
  endfunction

  function automatic logic day_fits(input logic [4:0] d, input logic [3:0] m,
                                    input logic [13:0] y);
    int unsigned len;
    if (m < 4'd1 || m > 4'd12)
      return 1'b0;
    len = (m == 4'd2 && leap_year(32'(y))) ? 29 : common_len(32'(m));
    return (d >= 5'd1 && 32'(d) <= len);
  endfunction

  function automatic gdd_pkg::result_t days_between(input gdd_pkg::dates_t x);
    gdd_pkg::result_t r;
    int unsigned      na;
    int unsigned      nb;
    int unsigned      span;
    if (x.year_a != x.year_b)
      r.order = (x.year_a > x.year_b) ? gdd_pkg::ORD_LATER : gdd_pkg::ORD_EARLIER;
    else if (x.month_a != x.month_b)
      r.order = (x.month_a > x.month_b) ? gdd_pkg::ORD_LATER : gdd_pkg::ORD_EARLIER;
    else if (x.day_a != x.day_b)
      r.order = (x.day_a > x.day_b) ? gdd_pkg::ORD_LATER : gdd_pkg::ORD_EARLIER;
    else
      r.order = gdd_pkg::ORD_EQUAL;
    na = day_number(x.day_a, x.month_a, x.year_a);
    nb = day_number(x.day_b, x.month_b, x.year_b);
    span = (na > nb) ? na - nb : nb - na;
    r.days_apart = (span > 32'(gdd_pkg::DAYS_MAX)) ? gdd_pkg::DAYS_MAX : span[21:0];
    r.valid_a = day_fits(x.day_a, x.month_a, x.year_a);
    r.valid_b = day_fits(x.day_b, x.month_b, x.year_b);
    return r;
  endfunction

  task automatic flag(input string what, input int unsigned want, input int unsigned got);
    if (mismatches < 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    gdd_pkg::result_t want;
    if (!rst) begin
      // retire before enqueue so a stray done never eats this edge's item
      if (done) begin
        if (pending_results.size() == 0) begin
          flag("unexpected result, days_apart", 0, 32'(result.days_apart));
        end else begin
          want = pending_results.pop_front();
          if (result.order !== want.order)
            flag("order", 32'(want.order), 32'(result.order));
          if (result.days_apart !== want.days_apart)
            flag("days_apart", 32'(want.days_apart), 32'(result.days_apart));
          if (result.valid_a !== want.valid_a)
            flag("valid_a", 32'(want.valid_a), 32'(result.valid_a));
          if (result.valid_b !== want.valid_b)
            flag("valid_b", 32'(want.valid_b), 32'(result.valid_b));
        end
      end
      if (start && !busy)
        pending_results.push_back(days_between(dates));
      outstanding <= pending_results.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the date difference block. Result prediction and
// comparison live in date_diff_checker; this module feeds items and runs a watchdog.
module tb_top;

  localparam int unsigned RANDOM_ITEMS = 1300;
  // longest honest quiet stretch is the largest send_dates gap plus the pipeline
  localparam int unsigned STALL_LIMIT  = 1000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  gdd_pkg::dates_t  dates;
  logic             done;
  gdd_pkg::result_t result;
  int unsigned      mismatches;
  int unsigned      outstanding;
  int unsigned      quiet_cycles;

  gregorian_date_difference i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .dates  (dates),
    .done   (done),
    .result (result)
  );

  date_diff_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .dates       (dates),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any edge with reset, an accepted item or a result resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no traffic for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic gdd_pkg::dates_t mk(input int unsigned da, input int unsigned ma,
                                         input int unsigned ya, input int unsigned db,
                                         input int unsigned mb, input int unsigned yb);
    gdd_pkg::dates_t d;
    d.day_a   = 5'(da);
    d.month_a = 4'(ma);
    d.year_a  = 14'(ya);
    d.day_b   = 5'(db);
    d.month_b = 4'(mb);
    d.year_b  = 14'(yb);
    return d;
  endfunction

  // Mostly plausible dates, with shared year/month to reach the later
  // compare fields, leap-year corners, raw bit noise and near-equal pairs.
  function automatic gdd_pkg::dates_t random_dates();
    logic [63:0]     raw;
    int unsigned     pick;
    gdd_pkg::dates_t d;
    pick = $urandom_range(0, 99);
    d = mk($urandom_range(1, $urandom_range(0, 1) ? 28 : 31), $urandom_range(1, 12),
           $urandom_range(1, 9999),
           $urandom_range(1, $urandom_range(0, 1) ? 28 : 31), $urandom_range(1, 12),
           $urandom_range(1, 9999));
    if (pick < 40) begin
      // independent dates as drawn
    end else if (pick < 55) begin
      d.year_b = d.year_a;
    end else if (pick < 67) begin
      d.year_b  = d.year_a;
      d.month_b = d.month_a;
    end else if (pick < 77) begin
      // around Feb 29 in years hit by each leap rule
      case ($urandom_range(0, 2))
        0:       d.year_a = 14'(4 * $urandom_range(1, 2499));
        1:       d.year_a = 14'(100 * $urandom_range(1, 99));
        default: d.year_a = 14'(400 * $urandom_range(0, 24));
      endcase
      d.month_a = 4'($urandom_range(2, 3));
      d.day_a   = 5'((d.month_a == 4'd2) ? $urandom_range(28, 29) : 1);
      d.year_b  = 14'(32'(d.year_a) + $urandom_range(0, 1));
      d.month_b = 4'($urandom_range(2, 3));
      d.day_b   = 5'($urandom_range(1, 29));
    end else if (pick < 87) begin
      raw = {$urandom, $urandom};
      d   = raw[45:0];
    end else begin
      d.year_b  = d.year_a;
      d.month_b = d.month_a;
      d.day_b   = 5'(32'(d.day_a) + $urandom_range(0, 1));
    end
    return d;
  endfunction

  // start stays high across back-to-back items; this task lowers it only for a gap
  task automatic send_dates(input gdd_pkg::dates_t d, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    dates <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    bit burst;
    rst   = 1'b1;
    start = 1'b0;
    dates = '0;
    burst = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: equal dates, widest valid span both ways, all-zero vs all-one
    // fields (saturates), leap rules, Feb 31 vs Mar 1 order/count disagreement,
    // day 0, months 0 and 13..15, year 0, years past 9999.
    send_dates(mk(1, 1, 1, 1, 1, 1), 0);
    send_dates(mk(1, 1, 1, 31, 12, 9999), 0);
    send_dates(mk(31, 12, 9999, 1, 1, 1), 0);
    send_dates(mk(0, 0, 0, 31, 15, 16383), 0);
    send_dates(mk(31, 15, 16383, 0, 0, 0), 3);
    send_dates(mk(29, 2, 2000, 29, 2, 1900), 0);
    send_dates(mk(29, 2, 2004, 29, 2, 2001), 1);
    send_dates(mk(31, 2, 2020, 1, 3, 2020), 0);
    send_dates(mk(31, 4, 2021, 30, 4, 2021), 0);
    send_dates(mk(0, 1, 2021, 31, 12, 2020), 0);
    send_dates(mk(1, 13, 2020, 1, 1, 2021), 2);
    send_dates(mk(1, 14, 2020, 1, 15, 2020), 0);
    send_dates(mk(1, 0, 2020, 1, 1, 2020), 0);
    send_dates(mk(1, 3, 0, 28, 2, 0), 0);
    send_dates(mk(29, 2, 0, 1, 1, 1), 5);
    send_dates(mk(31, 12, 1999, 1, 1, 2000), 0);
    send_dates(mk(15, 6, 2024, 15, 6, 2024), 0);
    send_dates(mk(1, 1, 4000, 1, 1, 3999), 0);
    send_dates(mk(31, 12, 16383, 1, 1, 1), 10);
    send_dates(mk(30, 11, 2023, 31, 11, 2023), 0);
    send_dates(mk(31, 7, 2022, 31, 8, 2022), 0);
    drain();

    // Random: every 40 items pick a gapless burst or random gaps.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0)
        burst = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_ITEMS / 2)
        drain();
      send_dates(random_dates(), burst ? 0 : $urandom_range(0, 10));
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // keep clocking so a stray late result is still caught
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: gregorian_date_difference.f
rtl/gdd_pkg.sv
rtl/gdd_lane.sv
rtl/gdd_diff.sv
rtl/gregorian_date_difference.sv
rtl/gdd_checker.sv
dv/date_diff_checker.sv
dv/tb_top.sv
